@@ rtl/mws_pkg.sv @@
// Shared constants, widths and types for the mass-weighted separation unit.
package mws_pkg;

	localparam int FRAC_BITS = 16;
	localparam int VEC_W     = 18;
	localparam int DEPTH_W   = 24;
	localparam int MASS_W    = 24;

	// product of |normal| and depth, and the push magnitude taken from it
	localparam int PROD_W    = VEC_W + DEPTH_W;
	localparam int MAG_W     = VEC_W - 1 + DEPTH_W - FRAC_BITS;

	// squared length and its root
	localparam int SQ_W      = 2 * MAG_W;
	localparam int LEN2_W    = SQ_W + 2;
	localparam int SQ_STEPS  = LEN2_W / 2;
	localparam int LEN_W     = LEN2_W / 2;

	// dividers: quotients never exceed 1.0
	localparam int SUM_W     = MASS_W + 1;
	localparam int DEN_W     = (LEN_W > SUM_W) ? LEN_W : SUM_W;
	localparam int NUM_W     = MAG_W;
	localparam int Q_W       = FRAC_BITS + 1;
	localparam int DIV_STEPS = Q_W;

	// divider lanes: three push components, then the two weights
	localparam int LANES     = 5;
	localparam int LANE_WA   = 3;
	localparam int LANE_WB   = 4;

	localparam int FIFO_DEPTH = 2;

	typedef struct packed {
		logic [2:0][MAG_W-1:0] mag;
		logic [2:0]            neg;
		logic                  norm;
		logic                  both;
		logic                  one_a;
		logic                  one_b;
		logic                  sum_zero;
		logic [NUM_W-1:0]      num_a;
		logic [NUM_W-1:0]      num_b;
		logic [SUM_W-1:0]      msum;
	} side_t;

endpackage

@@ rtl/mws_front.sv @@
// Front end: push magnitudes, squared length and the weighting mode.
module mws_front (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      en,
	input  logic                                      in_valid,
	input  logic [mws_pkg::DEPTH_W-1:0]               depth,
	input  logic [2:0][mws_pkg::VEC_W-1:0]            normal,
	input  logic [mws_pkg::MASS_W-1:0]                mass_a,
	input  logic [mws_pkg::MASS_W-1:0]                mass_b,
	input  logic                                      awake_a,
	input  logic                                      awake_b,
	input  logic                                      no_push_a,
	input  logic                                      no_push_b,
	output logic                                      out_valid,
	output logic [mws_pkg::LEN2_W-1:0]                len2,
	output mws_pkg::side_t                            side
);

	localparam int PW  = mws_pkg::PROD_W;
	localparam int MW  = mws_pkg::MAG_W;
	localparam int SW  = mws_pkg::SQ_W;
	localparam int L2W = mws_pkg::LEN2_W;
	localparam int NW  = mws_pkg::NUM_W;
	localparam int UW  = mws_pkg::SUM_W;
	localparam int VW  = mws_pkg::VEC_W;
	localparam int FB  = mws_pkg::FRAC_BITS;
	localparam logic [L2W-1:0] ONE_SQ = L2W'(1) << (2 * FB);

	logic [2:0][VW-1:0] absn;
	logic [2:0][PW-1:0] prod;
	logic               aa;
	logic               ab;
	logic [L2W-1:0]     len2_c;
	mws_pkg::side_t     side_c2;
	mws_pkg::side_t     side_c3;

	logic               v_s1, v_s2, v_s3;
	logic [2:0][MW-1:0] mag_s1;
	logic [2:0]         neg_s1;
	logic               both_s1, one_a_s1, one_b_s1;
	logic [NW-1:0]      num_a_s1, num_b_s1;
	logic [UW-1:0]      msum_s1;
	logic [2:0][SW-1:0] sq_s2;
	mws_pkg::side_t     side_s2;
	logic [L2W-1:0]     len2_s3;
	mws_pkg::side_t     side_s3;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			absn[i] = normal[i][VW-1] ? (~normal[i] + 1'b1) : normal[i];
			prod[i] = PW'(absn[i]) * PW'(depth);
		end
		aa = awake_a;
		ab = awake_b;
		if (awake_a && awake_b) begin
			priority if (no_push_a) begin
				aa = 1'b0;
			end else if (no_push_b) begin
				ab = 1'b0;
			end else begin
			end
		end
		len2_c = L2W'(sq_s2[0]) + L2W'(sq_s2[1]) + L2W'(sq_s2[2]);

		side_c2.mag      = mag_s1;
		side_c2.neg      = neg_s1;
		side_c2.norm     = 1'b0;
		side_c2.both     = both_s1;
		side_c2.one_a    = one_a_s1;
		side_c2.one_b    = one_b_s1;
		side_c2.sum_zero = (msum_s1 == '0);
		side_c2.num_a    = num_a_s1;
		side_c2.num_b    = num_b_s1;
		side_c2.msum     = msum_s1;

		side_c3      = side_s2;
		side_c3.norm = (len2_c > ONE_SQ);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				mag_s1[i] <= prod[i][FB +: MW];
				neg_s1[i] <= normal[i][VW-1];
				sq_s2[i]  <= SW'(mag_s1[i]) * SW'(mag_s1[i]);
			end
			both_s1  <= aa && ab;
			one_a_s1 <= aa && !ab;
			one_b_s1 <= ab && !aa;
			num_a_s1 <= NW'(mass_b);
			num_b_s1 <= NW'(mass_a);
			msum_s1  <= UW'(mass_a) + UW'(mass_b);

			side_s2  <= side_c2;

			len2_s3  <= len2_c;
			side_s3  <= side_c3;
		end
	end

	assign out_valid = v_s3;
	assign len2      = len2_s3;
	assign side      = side_s3;

endmodule

@@ rtl/mws_sqrt.sv @@
// Pipelined integer square root, one result bit per stage.
module mws_sqrt (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  logic [mws_pkg::LEN2_W-1:0]  len2,
	input  mws_pkg::side_t              side_in,
	output logic                        out_valid,
	output logic [mws_pkg::LEN_W-1:0]   root,
	output mws_pkg::side_t              side_out
);

	localparam int N   = mws_pkg::SQ_STEPS;
	localparam int L2W = mws_pkg::LEN2_W;
	localparam int LW  = mws_pkg::LEN_W;

	logic [N-1:0]   v_s;
	logic [L2W-1:0] rem_s  [N];
	logic [L2W-1:0] root_s [N];
	mws_pkg::side_t side_s [N];

	logic [N-1:0]   v_src;
	logic [L2W-1:0] rem_src  [N];
	logic [L2W-1:0] root_src [N];
	mws_pkg::side_t side_src [N];
	logic [L2W-1:0] bitv  [N];
	logic [L2W-1:0] trial [N];
	logic [N-1:0]   ge;

	always_comb begin
		v_src[0]    = in_valid;
		rem_src[0]  = len2;
		root_src[0] = '0;
		side_src[0] = side_in;
		for (int k = 1; k < N; k++) begin
			v_src[k]    = v_s[k-1];
			rem_src[k]  = rem_s[k-1];
			root_src[k] = root_s[k-1];
			side_src[k] = side_s[k-1];
		end
		for (int k = 0; k < N; k++) begin
			bitv[k]  = L2W'(1) << (L2W - 2 - 2 * k);
			trial[k] = root_src[k] + bitv[k];
			ge[k]    = (rem_src[k] >= trial[k]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= v_src;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < N; k++) begin
				if (ge[k]) begin
					rem_s[k]  <= rem_src[k] - trial[k];
					root_s[k] <= (root_src[k] >> 1) + bitv[k];
				end else begin
					rem_s[k]  <= rem_src[k];
					root_s[k] <= root_src[k] >> 1;
				end
				side_s[k] <= side_src[k];
			end
		end
	end

	assign out_valid = v_s[N-1];
	assign root      = root_s[N-1][LW-1:0];
	assign side_out  = side_s[N-1];

endmodule

@@ rtl/mws_div.sv @@
// Pipelined restoring dividers, five lanes in lockstep, one quotient bit per stage.
module mws_div (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        en,
	input  logic                                        in_valid,
	input  logic [mws_pkg::LANES-1:0][mws_pkg::NUM_W-1:0] num,
	input  logic [mws_pkg::DEN_W-1:0]                   den_len,
	input  logic [mws_pkg::DEN_W-1:0]                   den_sum,
	input  mws_pkg::side_t                              side_in,
	output logic                                        out_valid,
	output logic [mws_pkg::LANES-1:0][mws_pkg::Q_W-1:0] quo,
	output mws_pkg::side_t                              side_out
);

	localparam int N  = mws_pkg::DIV_STEPS;
	localparam int NL = mws_pkg::LANES;
	localparam int DW = mws_pkg::DEN_W;
	localparam int QW = mws_pkg::Q_W;

	logic [N-1:0]                v_s;
	logic [NL-1:0][DW-1:0]       rem_s  [N];
	logic [NL-1:0][QW-1:0]       quo_s  [N];
	logic [1:0][DW-1:0]          den_s  [N];
	mws_pkg::side_t              side_s [N];

	logic [N-1:0]                v_src;
	logic [NL-1:0][DW-1:0]       rem_src  [N];
	logic [NL-1:0][QW-1:0]       quo_src  [N];
	logic [1:0][DW-1:0]          den_src  [N];
	mws_pkg::side_t              side_src [N];
	logic [NL-1:0]               bit_src  [N];
	logic [NL-1:0][DW:0]         part [N];
	logic [NL-1:0][DW:0]         dext [N];
	logic [NL-1:0]               ge   [N];

	always_comb begin
		v_src[0]    = in_valid;
		den_src[0]  = {den_sum, den_len};
		side_src[0] = side_in;
		for (int l = 0; l < NL; l++) begin
			rem_src[0][l] = DW'(num[l] >> 1);
			quo_src[0][l] = '0;
			bit_src[0][l] = num[l][0];
		end
		for (int k = 1; k < N; k++) begin
			v_src[k]    = v_s[k-1];
			rem_src[k]  = rem_s[k-1];
			quo_src[k]  = quo_s[k-1];
			den_src[k]  = den_s[k-1];
			side_src[k] = side_s[k-1];
			bit_src[k]  = '0;
		end
		for (int k = 0; k < N; k++) begin
			for (int l = 0; l < NL; l++) begin
				part[k][l] = {rem_src[k][l], bit_src[k][l]};
				dext[k][l] = (l < mws_pkg::LANE_WA) ? {1'b0, den_src[k][0]}
				                                    : {1'b0, den_src[k][1]};
				ge[k][l]   = (part[k][l] >= dext[k][l]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= v_src;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < N; k++) begin
				for (int l = 0; l < NL; l++) begin
					if (ge[k][l]) begin
						rem_s[k][l] <= DW'(part[k][l] - dext[k][l]);
					end else begin
						rem_s[k][l] <= DW'(part[k][l]);
					end
					quo_s[k][l] <= {quo_src[k][l][QW-2:0], ge[k][l]};
				end
				den_s[k]  <= den_src[k];
				side_s[k] <= side_src[k];
			end
		end
	end

	assign out_valid = v_s[N-1];
	assign quo       = quo_s[N-1];
	assign side_out  = side_s[N-1];

endmodule

@@ rtl/mws_back.sv @@
// Back end: weight selection, push times weight, and sign restore.
module mws_back (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        en,
	input  logic                                        in_valid,
	input  logic [mws_pkg::LANES-1:0][mws_pkg::Q_W-1:0] quo,
	input  mws_pkg::side_t                              side,
	output logic                                        out_valid,
	output logic [2:0][mws_pkg::VEC_W-1:0]              move_a,
	output logic [2:0][mws_pkg::VEC_W-1:0]              move_b
);

	localparam int QW = mws_pkg::Q_W;
	localparam int PW = 2 * QW;
	localparam int VW = mws_pkg::VEC_W;
	localparam int FB = mws_pkg::FRAC_BITS;
	localparam logic [QW-1:0] ONE = QW'(1) << FB;

	logic [2:0][QW-1:0] magf;
	logic [QW-1:0]      wa;
	logic [QW-1:0]      wb;
	logic [2:0][VW-1:0] ma_ext;
	logic [2:0][VW-1:0] mb_ext;

	logic               v_s1, v_s2;
	logic [2:0][PW-1:0] prod_a_s1, prod_b_s1;
	logic [2:0]         neg_s1;
	logic [2:0][VW-1:0] move_a_s2, move_b_s2;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			magf[i] = side.norm ? quo[i] : side.mag[i][QW-1:0];
		end
		if (side.both) begin
			wa = side.sum_zero ? '0 : quo[mws_pkg::LANE_WA];
			wb = side.sum_zero ? '0 : quo[mws_pkg::LANE_WB];
		end else begin
			wa = side.one_a ? ONE : '0;
			wb = side.one_b ? ONE : '0;
		end
		for (int i = 0; i < 3; i++) begin
			ma_ext[i] = VW'(prod_a_s1[i][FB +: QW]);
			mb_ext[i] = VW'(prod_b_s1[i][FB +: QW]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				prod_a_s1[i] <= PW'(magf[i]) * PW'(wa);
				prod_b_s1[i] <= PW'(magf[i]) * PW'(wb);
				move_a_s2[i] <= neg_s1[i] ? (~ma_ext[i] + 1'b1) : ma_ext[i];
				move_b_s2[i] <= neg_s1[i] ? mb_ext[i] : (~mb_ext[i] + 1'b1);
			end
			neg_s1 <= side.neg;
		end
	end

	assign out_valid = v_s2;
	assign move_a    = move_a_s2;
	assign move_b    = move_b_s2;

endmodule

@@ rtl/mass_weighted_separation_unit.sv @@
// Top level of the mass-weighted separation unit: pipeline and output queue.
//
// Takes one contact request per cycle on the input channel (in_valid/in_stall):
// depth, contact normal, both masses and the awake and never-push flags. Gives
// one result per request on the output channel (out_valid/out_stall): the
// displacement of body A and of body B, Q1.16 each, in request order.
// From acceptance to out_valid a request passes three front stages (multiply,
// square, sum), 26 square-root stages at one root bit each, 17 divider stages
// at one quotient bit each (push scaling and both weights share these stages),
// two back stages (weight multiply, sign), and the output queue. The pipeline
// takes one request per cycle while the queue has room and in_stall is low.
// Results land in a two-entry queue that drives the output ports, so requests
// keep flowing while a result waits. When the queue is full the whole pipeline
// holds and in_stall rises; nothing is dropped or repeated. Reset clears all
// valid bits and the queue; data registers are not reset.
module mass_weighted_separation_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic        [23:0]                depth,
	input  logic signed [17:0]                normal_x,
	input  logic signed [17:0]                normal_y,
	input  logic signed [17:0]                normal_z,
	input  logic        [23:0]                mass_a,
	input  logic        [23:0]                mass_b,
	input  logic                              awake_a,
	input  logic                              awake_b,
	input  logic                              no_push_a,
	input  logic                              no_push_b,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [17:0]                move_a_x,
	output logic signed [17:0]                move_a_y,
	output logic signed [17:0]                move_a_z,
	output logic signed [17:0]                move_b_x,
	output logic signed [17:0]                move_b_y,
	output logic signed [17:0]                move_b_z
);

	localparam int VW  = mws_pkg::VEC_W;
	localparam int DW  = mws_pkg::DEN_W;
	localparam int NW  = mws_pkg::NUM_W;
	localparam int FD  = mws_pkg::FIFO_DEPTH;
	localparam int CW  = $clog2(FD + 1);
	localparam int PTW = $clog2(FD);

	// pipeline enable: the whole pipe advances while the queue has room
	logic en;

	logic [2:0][VW-1:0] normal;

	logic                                   fr_v;
	logic [mws_pkg::LEN2_W-1:0]             fr_len2;
	mws_pkg::side_t                         fr_side;

	logic                                   sq_v;
	logic [mws_pkg::LEN_W-1:0]              sq_root;
	mws_pkg::side_t                         sq_side;

	logic [mws_pkg::LANES-1:0][NW-1:0]      dv_num;
	logic                                   dv_v;
	logic [mws_pkg::LANES-1:0][mws_pkg::Q_W-1:0] dv_quo;
	mws_pkg::side_t                         dv_side;

	logic                                   bk_v;
	logic [2:0][VW-1:0]                     bk_move_a;
	logic [2:0][VW-1:0]                     bk_move_b;

	// output queue
	logic [5:0][VW-1:0] fifo_q [FD];
	logic [PTW-1:0]     wr_ptr_q;
	logic [PTW-1:0]     rd_ptr_q;
	logic [CW-1:0]      count_q;
	logic               push;
	logic               pop;
	logic [5:0][VW-1:0] head;

	assign normal = {normal_z, normal_y, normal_x};

	assign en       = (count_q != CW'(FD));
	assign in_stall = !en;

	mws_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (in_valid),
		.depth     (depth),
		.normal    (normal),
		.mass_a    (mass_a),
		.mass_b    (mass_b),
		.awake_a   (awake_a),
		.awake_b   (awake_b),
		.no_push_a (no_push_a),
		.no_push_b (no_push_b),
		.out_valid (fr_v),
		.len2      (fr_len2),
		.side      (fr_side)
	);

	mws_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (fr_v),
		.len2      (fr_len2),
		.side_in   (fr_side),
		.out_valid (sq_v),
		.root      (sq_root),
		.side_out  (sq_side)
	);

	// the three push components divide by the length, the weights by the mass sum
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			dv_num[i] = sq_side.mag[i];
		end
		dv_num[mws_pkg::LANE_WA] = sq_side.num_a;
		dv_num[mws_pkg::LANE_WB] = sq_side.num_b;
	end

	mws_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (sq_v),
		.num       (dv_num),
		.den_len   (DW'(sq_root)),
		.den_sum   (DW'(sq_side.msum)),
		.side_in   (sq_side),
		.out_valid (dv_v),
		.quo       (dv_quo),
		.side_out  (dv_side)
	);

	mws_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (dv_v),
		.quo       (dv_quo),
		.side      (dv_side),
		.out_valid (bk_v),
		.move_a    (bk_move_a),
		.move_b    (bk_move_b)
	);

	// queue: push what leaves the pipe, pop on a completed output request
	assign push = en && bk_v;
	assign pop  = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTW'(FD - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTW'(FD - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + CW'(push) - CW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= {bk_move_b, bk_move_a};
		end
	end

	assign head      = fifo_q[rd_ptr_q];
	assign out_valid = (count_q != '0);
	assign move_a_x  = head[0];
	assign move_a_y  = head[1];
	assign move_a_z  = head[2];
	assign move_b_x  = head[3];
	assign move_b_y  = head[4];
	assign move_b_z  = head[5];

	// the queue never holds more than its depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(FD))
		else $error("output queue overfilled");

	// input is held back only while results are waiting in the queue
	a_stall_needs_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with an empty output queue");

	// a completed pop with no push drains exactly one entry
	a_pop_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !push) |=> (count_q == $past(count_q) - 1'b1))
		else $error("queue count wrong after pop");

endmodule

@@ bench/tb_mass_weighted_separation_unit.sv @@
// Self-checking bench for the mass-weighted separation unit: directed and random contacts.
`timescale 1ns / 1ps

module tb_mass_weighted_separation_unit;

	localparam int LATENCY   = 49;
	localparam int MAX_CYCLE = 1500000;
	localparam int N_RANDOM  = 1700;

	typedef struct {
		logic signed [17:0] ax, ay, az, bx, by, bz;
	} separation_t;

	// Holds the expected displacements in request order and compares results.
	class separation_board;
		separation_t pending[$];
		int mismatches;

		function void note_request(separation_t s);
			pending.push_back(s);
		endfunction

		function void report_mismatch(string what, logic [17:0] got, logic [17:0] want);
			$display("mismatch %s: got %0h want %0h", what, got, want);
			mismatches++;
		endfunction

		function void check_result(separation_t got);
			separation_t want;
			if (pending.size() == 0) begin
				report_mismatch("result with no request outstanding", got.ax, '0);
				return;
			end
			want = pending.pop_front();
			if (got.ax !== want.ax) report_mismatch("move_a_x", got.ax, want.ax);
			if (got.ay !== want.ay) report_mismatch("move_a_y", got.ay, want.ay);
			if (got.az !== want.az) report_mismatch("move_a_z", got.az, want.az);
			if (got.bx !== want.bx) report_mismatch("move_b_x", got.bx, want.bx);
			if (got.by !== want.by) report_mismatch("move_b_y", got.by, want.by);
			if (got.bz !== want.bz) report_mismatch("move_b_z", got.bz, want.bz);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [23:0] depth = '0;
	logic signed [17:0] normal_x = '0, normal_y = '0, normal_z = '0;
	logic [23:0] mass_a = '0, mass_b = '0;
	logic awake_a = 1'b0, awake_b = 1'b0, no_push_a = 1'b0, no_push_b = 1'b0;
	logic out_valid;
	logic out_stall = 1'b1;
	logic signed [17:0] move_a_x, move_a_y, move_a_z, move_b_x, move_b_y, move_b_z;

	separation_board board;
	int send_idle_pct = 0;   // chance per cycle that the sender holds back
	int recv_stall_pct = 0;  // chance per cycle that the receiver stalls
	int hold_off = 0;        // long receiver hold-off, in cycles
	int cycle = 0;

	mass_weighted_separation_unit dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Integer square root, floor.
	function automatic longint unsigned root_floor(longint unsigned v);
		longint unsigned r = 0, b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic logic [17:0] signed_field(bit neg, longint unsigned m);
		longint s;
		s = neg ? -longint'(m) : longint'(m);
		return s[17:0];
	endfunction

	// Work out both displacements of one contact request.
	function automatic separation_t separate(logic [23:0] d, logic [17:0] n[3],
			logic [23:0] ma, logic [23:0] mb, bit wake_a, bit wake_b, bit np_a, bit np_b);
		separation_t r;
		bit neg[3];
		longint unsigned mag[3], len2 = 0, len, wa = 0, wb = 0, sum;
		logic [17:0] oa[3], ob[3];
		for (int i = 0; i < 3; i++) begin
			neg[i] = n[i][17];
			mag[i] = ((neg[i] ? 64'h40000 - n[i] : 64'(n[i])) * d) >> 16;
			len2 += mag[i] * mag[i];
		end
		if (len2 > (64'd1 << 32)) begin
			len = root_floor(len2);
			if (len != 0)
				for (int i = 0; i < 3; i++) mag[i] = (mag[i] << 16) / len;
		end
		if (wake_a && wake_b) begin
			if (np_a) wake_a = 0;
			else if (np_b) wake_b = 0;
		end
		if (wake_a && wake_b) begin
			sum = ma + mb;
			if (sum != 0) begin
				wa = (64'(mb) << 16) / sum;
				wb = (64'(ma) << 16) / sum;
			end
		end else if (wake_a) begin
			wa = 64'd1 << 16;
		end else if (wake_b) begin
			wb = 64'd1 << 16;
		end
		for (int i = 0; i < 3; i++) begin
			oa[i] = signed_field(neg[i], (mag[i] * wa) >> 16);
			ob[i] = signed_field(!neg[i], (mag[i] * wb) >> 16);
		end
		r.ax = oa[0]; r.ay = oa[1]; r.az = oa[2];
		r.bx = ob[0]; r.by = ob[1]; r.bz = ob[2];
		return r;
	endfunction

	// Offer one request, idling first at random; advance once accepted.
	task automatic send_contact(logic [23:0] d, logic [17:0] nx, logic [17:0] ny,
			logic [17:0] nz, logic [23:0] ma, logic [23:0] mb, bit [3:0] flags);
		logic [17:0] n[3];
		n[0] = nx; n[1] = ny; n[2] = nz;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		depth <= d; normal_x <= nx; normal_y <= ny; normal_z <= nz;
		mass_a <= ma; mass_b <= mb;
		{awake_a, awake_b, no_push_a, no_push_b} <= flags;
		do @(posedge clk); while (in_stall);
		board.note_request(separate(d, n, ma, mb, flags[3], flags[2], flags[1], flags[0]));
	endtask

	function automatic logic [17:0] random_normal();
		case ($urandom_range(5))
			0: return 18'sd65536;
			1: return -18'sd65536;
			2: return 18'($urandom_range(65536));
			3: return -18'($urandom_range(65536));
			4: return 18'($urandom_range(255)) - 18'sd128;
			default: return 18'($urandom);   // any bit pattern, out of range too
		endcase
	endfunction

	function automatic logic [23:0] random_wide();
		case ($urandom_range(3))
			0: return 24'($urandom_range(255));
			1: return 24'hFFFFFF - 24'($urandom_range(255));
			default: return 24'($urandom);
		endcase
	endfunction

	// Receiver: stall at random, or hold off entirely while a hold-off runs.
	always @(posedge clk) begin
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
		if (arst_n && out_valid && !out_stall)
			board.check_result('{move_a_x, move_a_y, move_a_z, move_b_x, move_b_y, move_b_z});
	end

	// Watchdog: drop the run after a generous cycle count.
	always @(posedge clk) begin
		cycle <= cycle + 1;
		if (cycle > MAX_CYCLE) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		board = new();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: field extremes, every flag combination, zero sums, tiny weights.
		send_contact(24'hFFFFFF, 18'sd65536, 18'sd65536, -18'sd65536, 24'h100, 24'h100, 4'b1100);
		send_contact(24'h0, 18'sd65536, 18'd0, 18'd0, 24'h100, 24'h200, 4'b1100);
		send_contact(24'h10000, -18'sd65536, 18'd0, 18'd0, 24'd0, 24'd0, 4'b1100);
		send_contact(24'h8000, 18'd0, 18'sd46341, 18'sd46341, 24'hFFFFFF, 24'h1, 4'b1100);
		send_contact(24'h8000, 18'd0, 18'sd46341, -18'sd46341, 24'h1, 24'hFFFFFF, 4'b1100);
		send_contact(24'hFFFFFF, 18'h20000, 18'h1FFFF, 18'h3FFFF, 24'hFFFFFF, 24'hFFFFFF, 4'b1100);
		send_contact(24'h1, 18'sd1, -18'sd1, 18'd0, 24'h5, 24'h7, 4'b1100);
		for (int f = 0; f < 16; f++)
			send_contact(24'h18000, 18'sd30000, -18'sd40000, 18'sd20000, 24'h300, 24'h500, 4'(f));
		send_contact(24'h9000, 18'sd65536, 18'd0, 18'd0, 24'h0, 24'h0, 4'b1111);

		// Random phases: none, sender idle, receiver stalling, both, long receiver hold-off.
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
				3: begin send_idle_pct = 11; recv_stall_pct = 11; end
				default: begin send_idle_pct = 0; recv_stall_pct = 0; hold_off = 200; end
			endcase
			for (int i = 0; i < N_RANDOM / 5; i++)
				send_contact(random_wide(), random_normal(), random_normal(), random_normal(),
					random_wide(), random_wide(), 4'($urandom));
		end
		in_valid <= 1'b0;

		while (board.pending.size() != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		if (board.mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
